// File: rtl/tcuf_pkg.sv
// Shared types and constants for the three-class union-find checker.
// No dependencies.
package tcuf_pkg;

	localparam int unsigned COUNT_W = 20;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		REL_NONE0 = 2'd0,
		REL_SAME  = 2'd1,
		REL_BEATS = 2'd2,
		REL_NONE3 = 2'd3
	} rel_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_FRD,
		ST_FCK,
		ST_CRD,
		ST_CCK,
		ST_LINK,
		ST_RES
	} state_t;

endpackage

// File: rtl/tcuf_stmt_if.sv
// Input channel carrying one statement per beat.
// Depends on nothing.
interface tcuf_stmt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  relation;
	logic [15:0] first_entity;
	logic [15:0] second_entity;

	modport source (output valid, relation, first_entity, second_entity, input ready);
	modport sink (input valid, relation, first_entity, second_entity, output ready);
endinterface

// File: rtl/tcuf_verdict_if.sv
// Output channel carrying one verdict per beat.
// Depends on nothing.
interface tcuf_verdict_if;
	logic        valid;
	logic        ready;
	logic        is_false;
	logic [19:0] false_count;

	modport source (output valid, is_false, false_count, input ready);
	modport sink (input valid, is_false, false_count, output ready);
endinterface

// File: rtl/tcuf_ram.sv
// Generic single-write, single-read RAM with a registered read.
// Depends on nothing.
module tcuf_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/three_class_union_find_checker.sv
// Top level of the three-class union-find checker: sequencer, slot arithmetic and link RAM.
// Depends on tcuf_pkg, tcuf_stmt_if, tcuf_verdict_if and tcuf_ram.
//
//   channel  | direction | beat
//   stmt     | in        | relation, first_entity, second_entity
//   verdict  | out       | is_false, false_count
//   cfg      | in        | num_entities write (cfg_we, cfg_wdata)
//
// A statement with a bad id, an ignored code or a beats relation on equal ids goes straight
// to the result; any other runs up to ten finds, each climbing and then compressing its path,
// through the single read port and single write port of the link RAM, plus a link write
// per merge. After reset a clearing pass over all 3*MAX_ENTITIES+1 slots sets every link
// to itself; no statement is taken during it. A verdict waiting on a stalled output holds
// the next statement only at its own end.
module three_class_union_find_checker #(
	parameter int unsigned MAX_ENTITIES = 16384
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tcuf_stmt_if.sink             stmt,
	tcuf_verdict_if.source        verdict,
	input  logic                  cfg_we,
	input  logic [14:0]           cfg_wdata
);
	localparam int unsigned DEPTH = 3 * MAX_ENTITIES + 1;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned NW = $clog2(MAX_ENTITIES + 1);
	localparam int unsigned CW = (NW > 15) ? NW : 15;

	tcuf_pkg::state_t state_q, state_nx;

	logic [14:0]   n_q;
	logic [NW-1:0] n_eff;
	logic [AW-1:0] x_q [3];
	logic [AW-1:0] y_q [3];
	logic [1:0]    rel_q;
	logic [3:0]    k_q;
	logic [AW-1:0] cur_q, start_q, root_q, ra_q, clr_q, opnd;
	logic          bad_q;
	logic          ov_q, of_q;
	logic [tcuf_pkg::COUNT_W-1:0] cnt_q;

	logic          we;
	logic [AW-1:0] waddr, wdata, raddr, rdata;

	logic          acc, id_bad, x_eq_y, res_go, eq, comp_done, last_k;
	logic [AW-1:0] nx_slot;

	tcuf_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_links (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign n_eff = (CW'(n_q) > CW'(MAX_ENTITIES)) ? NW'(MAX_ENTITIES) : NW'(n_q);
	assign nx_slot = AW'(n_eff);
	assign acc = stmt.valid && stmt.ready;
	assign id_bad = (stmt.first_entity == 16'd0) || (stmt.second_entity == 16'd0)
		|| ({1'b0, stmt.first_entity} > 17'(n_eff))
		|| ({1'b0, stmt.second_entity} > 17'(n_eff));
	assign x_eq_y = (stmt.first_entity == stmt.second_entity);
	assign res_go = !ov_q || verdict.ready;
	assign eq = (ra_q == root_q);
	assign comp_done = (cur_q == root_q);
	assign last_k = (k_q == 4'd9);

	always_comb begin
		opnd = x_q[0];
		if (rel_q == tcuf_pkg::REL_SAME) begin
			unique case (k_q)
				4'd0, 4'd2, 4'd4: opnd = x_q[0];
				4'd1: opnd = y_q[1];
				4'd3: opnd = y_q[2];
				4'd5: opnd = y_q[0];
				4'd6: opnd = x_q[1];
				4'd7: opnd = y_q[1];
				4'd8: opnd = x_q[2];
				4'd9: opnd = y_q[2];
				default: opnd = x_q[0];
			endcase
		end else begin
			unique case (k_q)
				4'd0, 4'd2, 4'd4: opnd = x_q[0];
				4'd1: opnd = y_q[0];
				4'd3: opnd = y_q[2];
				4'd5: opnd = y_q[1];
				4'd6: opnd = x_q[1];
				4'd7: opnd = y_q[2];
				4'd8: opnd = x_q[2];
				4'd9: opnd = y_q[0];
				default: opnd = x_q[0];
			endcase
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tcuf_pkg::ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) state_nx = tcuf_pkg::ST_IDLE;
			end
			tcuf_pkg::ST_IDLE: begin
				if (acc) begin
					if (!id_bad && (stmt.relation == tcuf_pkg::REL_SAME
						|| (stmt.relation == tcuf_pkg::REL_BEATS && !x_eq_y)))
						state_nx = tcuf_pkg::ST_LOAD;
					else
						state_nx = tcuf_pkg::ST_RES;
				end
			end
			tcuf_pkg::ST_LOAD: state_nx = tcuf_pkg::ST_FRD;
			tcuf_pkg::ST_FRD: state_nx = tcuf_pkg::ST_FCK;
			tcuf_pkg::ST_FCK: begin
				if (rdata == cur_q) state_nx = tcuf_pkg::ST_CRD;
			end
			tcuf_pkg::ST_CRD: state_nx = tcuf_pkg::ST_CCK;
			tcuf_pkg::ST_CCK: begin
				if (comp_done) begin
					if (!k_q[0]) state_nx = tcuf_pkg::ST_LOAD;
					else if (k_q < 4'd4) state_nx = eq ? tcuf_pkg::ST_RES : tcuf_pkg::ST_LOAD;
					else if (!eq) state_nx = tcuf_pkg::ST_LINK;
					else state_nx = last_k ? tcuf_pkg::ST_RES : tcuf_pkg::ST_LOAD;
				end
			end
			tcuf_pkg::ST_LINK: state_nx = last_k ? tcuf_pkg::ST_RES : tcuf_pkg::ST_LOAD;
			tcuf_pkg::ST_RES: begin
				if (res_go) state_nx = tcuf_pkg::ST_IDLE;
			end
			default: state_nx = tcuf_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = cur_q;
		wdata = root_q;
		raddr = cur_q;
		stmt.ready = (state_q == tcuf_pkg::ST_IDLE);
		unique case (state_q)
			tcuf_pkg::ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = clr_q;
			end
			tcuf_pkg::ST_FCK: raddr = rdata;
			tcuf_pkg::ST_CCK: begin
				raddr = rdata;
				we = !comp_done;
			end
			tcuf_pkg::ST_LINK: begin
				we = 1'b1;
				waddr = ra_q;
				wdata = root_q;
			end
			default: raddr = cur_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcuf_pkg::ST_CLEAR;
			n_q <= 15'd16384;
			clr_q <= '0;
			ov_q <= 1'b0;
			cnt_q <= '0;
			k_q <= '0;
			bad_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) n_q <= cfg_wdata;
			if (verdict.ready) ov_q <= 1'b0;
			unique case (state_q)
				tcuf_pkg::ST_CLEAR: clr_q <= clr_q + AW'(1);
				tcuf_pkg::ST_IDLE: begin
					k_q <= '0;
					bad_q <= id_bad
						|| (stmt.relation == tcuf_pkg::REL_BEATS && x_eq_y);
				end
				tcuf_pkg::ST_CCK: begin
					if (comp_done) begin
						if (!k_q[0] || (k_q > 4'd4 && eq && !last_k) || (k_q < 4'd4 && !eq))
							k_q <= k_q + 4'd1;
						if (k_q[0] && k_q < 4'd4 && eq) bad_q <= 1'b1;
					end
				end
				tcuf_pkg::ST_LINK: begin
					if (!last_k) k_q <= k_q + 4'd1;
				end
				tcuf_pkg::ST_RES: begin
					if (res_go) begin
						ov_q <= 1'b1;
						if (bad_q && cnt_q != tcuf_pkg::COUNT_MAX)
							cnt_q <= cnt_q + (tcuf_pkg::COUNT_W)'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rel_q <= stmt.relation;
			x_q[0] <= AW'(stmt.first_entity);
			x_q[1] <= AW'(stmt.first_entity) + nx_slot;
			x_q[2] <= AW'(stmt.first_entity) + nx_slot + nx_slot;
			y_q[0] <= AW'(stmt.second_entity);
			y_q[1] <= AW'(stmt.second_entity) + nx_slot;
			y_q[2] <= AW'(stmt.second_entity) + nx_slot + nx_slot;
		end
		unique case (state_q)
			tcuf_pkg::ST_LOAD: begin
				cur_q <= opnd;
				start_q <= opnd;
			end
			tcuf_pkg::ST_FCK: begin
				if (rdata == cur_q) begin
					root_q <= cur_q;
					cur_q <= start_q;
				end else begin
					cur_q <= rdata;
				end
			end
			tcuf_pkg::ST_CCK: begin
				if (comp_done) begin
					if (!k_q[0]) ra_q <= root_q;
				end else begin
					cur_q <= rdata;
				end
			end
			tcuf_pkg::ST_RES: begin
				if (res_go) of_q <= bad_q;
			end
			default: ;
		endcase
	end

	assign verdict.valid = ov_q;
	assign verdict.is_false = of_q;
	assign verdict.false_count = cnt_q;
endmodule

// File: dv/tb_three_class_union_find_checker.sv
// Testbench for three_class_union_find_checker: directed and random statements, checked
// beat by beat against a predictor kept in the bench. Depends on tcuf_pkg, tcuf_stmt_if,
// tcuf_verdict_if and the checker RTL.
module tb_three_class_union_find_checker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAXN = 16384;
	localparam int unsigned SLOTS = 3 * MAXN + 1;

	typedef struct {
		logic            is_false;
		logic [tcuf_pkg::COUNT_W-1:0] false_count;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;

	tcuf_stmt_if stmt ();
	tcuf_verdict_if verdict ();

	three_class_union_find_checker #(.MAX_ENTITIES(MAXN)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.stmt(stmt.sink),
		.verdict(verdict.source),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	int unsigned links [0:SLOTS-1];
	logic [tcuf_pkg::COUNT_W-1:0] model_false_total;
	logic [14:0] model_n;
	verdict_t pending_verdicts [$];
	int unsigned fail_count = 0;
	int unsigned beats_checked = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned rx_hold = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		stmt.valid = 1'b0;
		stmt.relation = '0;
		stmt.first_entity = '0;
		stmt.second_entity = '0;
		verdict.ready = 1'b0;
	end

	function automatic int unsigned find_root(int unsigned x);
		int unsigned r;
		int unsigned nx;
		r = x;
		while (links[r] != r)
			r = links[r];
		while (x != r) begin
			nx = links[x];
			links[x] = r;
			x = nx;
		end
		return r;
	endfunction

	function automatic void merge_sets(int unsigned a, int unsigned b);
		int unsigned ra;
		int unsigned rb;
		ra = find_root(a);
		rb = find_root(b);
		if (ra != rb)
			links[ra] = rb;
	endfunction

	function automatic bit same_set(int unsigned a, int unsigned b);
		int unsigned ra;
		ra = find_root(a);
		return ra == find_root(b);
	endfunction

	function automatic void judge_statement(tcuf_pkg::rel_t rel, int unsigned x,
		int unsigned y);
		int unsigned n;
		bit bad;
		verdict_t v;
		n = (model_n > MAXN) ? MAXN : model_n;
		bad = 1'b0;
		if (x == 0 || y == 0 || x > n || y > n) begin
			bad = 1'b1;
		end else if (rel == tcuf_pkg::REL_SAME) begin
			if (same_set(x, y + n) || same_set(x, y + 2 * n)) begin
				bad = 1'b1;
			end else begin
				merge_sets(x, y);
				merge_sets(x + n, y + n);
				merge_sets(x + 2 * n, y + 2 * n);
			end
		end else if (rel == tcuf_pkg::REL_BEATS) begin
			if (x == y || same_set(x, y) || same_set(x, y + 2 * n)) begin
				bad = 1'b1;
			end else begin
				merge_sets(x, y + n);
				merge_sets(x + n, y + 2 * n);
				merge_sets(x + 2 * n, y);
			end
		end
		if (bad && model_false_total != tcuf_pkg::COUNT_MAX)
			model_false_total++;
		v.is_false = bad;
		v.false_count = model_false_total;
		pending_verdicts.push_back(v);
	endfunction

	task automatic send_statement(tcuf_pkg::rel_t rel, logic [15:0] x, logic [15:0] y);
		if ($urandom_range(99) < tx_idle_pct)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		stmt.valid = 1'b1;
		stmt.relation = rel;
		stmt.first_entity = x;
		stmt.second_entity = y;
		do @(posedge clk); while (!stmt.ready);
		judge_statement(rel, x, y);
		@(negedge clk);
		stmt.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_entities(logic [14:0] value);
		wait_drained();
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		model_n = value;
	endtask

	always @(negedge clk) begin
		if (rx_hold != 0) begin
			verdict.ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			verdict.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && verdict.valid && verdict.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("verdict beat with nothing expected");
				fail_count++;
			end else begin
				e = pending_verdicts.pop_front();
				beats_checked++;
				if (verdict.is_false !== e.is_false) begin
					$error("is_false: expected %0d, got %0d", e.is_false, verdict.is_false);
					fail_count++;
				end
				if (verdict.false_count !== e.false_count) begin
					$error("false_count: expected %0d, got %0d",
						e.false_count, verdict.false_count);
					fail_count++;
				end
			end
		end
	end

	function automatic tcuf_pkg::rel_t random_relation();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 45) return tcuf_pkg::REL_SAME;
		if (p < 90) return tcuf_pkg::REL_BEATS;
		return (p < 95) ? tcuf_pkg::REL_NONE0 : tcuf_pkg::REL_NONE3;
	endfunction

	function automatic logic [15:0] random_id(int unsigned n);
		int unsigned lim;
		lim = (n > MAXN) ? MAXN : n;
		if (lim == 0 || $urandom_range(99) < 5)
			return 16'($urandom_range(65535, 0));
		if ($urandom_range(99) < 3)
			return 16'(lim + 1);
		return 16'($urandom_range(lim, 1));
	endfunction

	task automatic test_directed();
		write_entities(15'd5);
		send_statement(tcuf_pkg::REL_SAME, 16'd0, 16'd1);
		send_statement(tcuf_pkg::REL_BEATS, 16'd1, 16'd6);
		send_statement(tcuf_pkg::REL_SAME, 16'hFFFF, 16'hFFFF);
		send_statement(tcuf_pkg::REL_NONE3, 16'd0, 16'd2);
		send_statement(tcuf_pkg::REL_NONE0, 16'd1, 16'd2);
		send_statement(tcuf_pkg::REL_NONE3, 16'd5, 16'd5);
		send_statement(tcuf_pkg::REL_SAME, 16'd1, 16'd1);
		send_statement(tcuf_pkg::REL_BEATS, 16'd1, 16'd2);
		send_statement(tcuf_pkg::REL_SAME, 16'd1, 16'd2);
		send_statement(tcuf_pkg::REL_BEATS, 16'd2, 16'd1);
		send_statement(tcuf_pkg::REL_BEATS, 16'd3, 16'd3);
		send_statement(tcuf_pkg::REL_BEATS, 16'd2, 16'd3);
		send_statement(tcuf_pkg::REL_BEATS, 16'd3, 16'd1);
		send_statement(tcuf_pkg::REL_BEATS, 16'd1, 16'd3);
		send_statement(tcuf_pkg::REL_SAME, 16'd3, 16'd2);
		send_statement(tcuf_pkg::REL_SAME, 16'd4, 16'd5);
		send_statement(tcuf_pkg::REL_BEATS, 16'd5, 16'd1);
		send_statement(tcuf_pkg::REL_SAME, 16'd4, 16'd3);
		send_statement(tcuf_pkg::REL_BEATS, 16'd4, 16'd2);
		send_statement(tcuf_pkg::REL_SAME, 16'd5, 16'd5);
	endtask

	task automatic test_random(logic [14:0] n, int unsigned count);
		write_entities(n);
		repeat (count)
			send_statement(random_relation(), random_id(n), random_id(n));
	endtask

	task automatic test_output_stall();
		rx_hold = 3000;
		repeat (40)
			send_statement(random_relation(), random_id(model_n), random_id(model_n));
	endtask

	task automatic test_sender_pause();
		repeat (30)
			send_statement(random_relation(), random_id(model_n), random_id(model_n));
		wait_drained();
		repeat (30)
			send_statement(random_relation(), random_id(model_n), random_id(model_n));
	endtask

	initial begin
		for (int unsigned i = 0; i < SLOTS; i++)
			links[i] = i;
		model_false_total = '0;
		model_n = 15'd16384;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 7;
		rx_idle_pct = 62;
		test_directed();
		test_random(15'd10, 300);
		test_random(15'd3, 200);
		test_output_stall();

		tx_idle_pct = 62;
		rx_idle_pct = 7;
		test_random(15'd50, 300);
		test_random(15'd1, 100);
		test_sender_pause();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random(15'd16384, 300);
		test_random(15'h7FFF, 150);
		test_random(15'd0, 50);
		test_random(15'd20, 400);

		wait_drained();
		$display("Checked %0d verdicts over entity counts 0 to 32767, with output stalls,",
			beats_checked);
		$display("a sender pause, out-of-range ids and ignored relation codes.");
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#200ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
